>>> hdl/vsps_pkg.sv
// ----------------------------------------------------------------------------
// vsps_pkg: shared types and constants for the panel selector
// Button layout, the "none" selection code and the result record.
// ----------------------------------------------------------------------------
package vsps_pkg;

    // Selection code for "no source selected"
    localparam logic [3:0] NONE_SEL = 4'd8;

    // Button bit layout in the pressed vector
    localparam int BTN_WIDTH = 18;
    localparam int PGM_BASE  = 0;
    localparam int PVW_BASE  = 8;
    localparam int CUT_BIT   = 16;
    localparam int TRANS_BIT = 17;
    localparam int BUS_BITS  = 8;

    // Bus selection state
    typedef struct packed {
        logic [BTN_WIDTH-1:0] previous_pressed;
        logic [3:0]           program_selection;
        logic [3:0]           preview_selection;
    } sel_state_t;

    // One result item
    typedef struct packed {
        logic       program_event;
        logic [3:0] program_source;
        logic       preview_event;
        logic [3:0] preview_source;
        logic       cut_event;
        logic       transition_event;
        logic       leds_event;
        logic [7:0] program_leds;
        logic [7:0] preview_leds;
    } result_t;

endpackage

>>> hdl/vsps_select.sv
// ----------------------------------------------------------------------------
// vsps_select: edge detection and bus selection for one button sample
// Finds new presses, toggles program/preview, applies cut/transition swaps
// and builds the LED masks. Pure combinational logic.
// ----------------------------------------------------------------------------
module vsps_select #(
    parameter int PGM_COUNT = 8,
    parameter int PVW_COUNT = 8
) (
    input  logic [vsps_pkg::BTN_WIDTH-1:0] button_levels,
    input  vsps_pkg::sel_state_t           state,
    output vsps_pkg::sel_state_t           state_next,
    output vsps_pkg::result_t              result
);

    localparam logic [7:0] PGM_MASK = 8'hFF >> (vsps_pkg::BUS_BITS - PGM_COUNT);
    localparam logic [7:0] PVW_MASK = 8'hFF >> (vsps_pkg::BUS_BITS - PVW_COUNT);

    logic [vsps_pkg::BTN_WIDTH-1:0] pressed;
    logic [vsps_pkg::BTN_WIDTH-1:0] edges;
    logic [7:0] pgm_edges;
    logic [7:0] pvw_edges;
    logic [2:0] pgm_idx;
    logic [2:0] pvw_idx;
    logic       pgm_hit;
    logic       pvw_hit;
    logic       cut_hit;
    logic       trans_hit;
    logic       any_hit;
    logic [3:0] pgm_sel;
    logic [3:0] pvw_sel;
    logic [3:0] pgm_final;
    logic [3:0] pvw_final;

    // Invert the active-low sample and find rising edges
    assign pressed   = ~button_levels;
    assign edges     = pressed & ~state.previous_pressed;
    assign pgm_edges = edges[vsps_pkg::PGM_BASE +: vsps_pkg::BUS_BITS] & PGM_MASK;
    assign pvw_edges = edges[vsps_pkg::PVW_BASE +: vsps_pkg::BUS_BITS] & PVW_MASK;
    assign cut_hit   = edges[vsps_pkg::CUT_BIT];
    assign trans_hit = edges[vsps_pkg::TRANS_BIT];
    assign pgm_hit   = |pgm_edges;
    assign pvw_hit   = |pvw_edges;
    assign any_hit   = pgm_hit | pvw_hit | cut_hit | trans_hit;

    // Pick the lowest new press on each bus
    always_comb
    begin
        pgm_idx = '0;
        pvw_idx = '0;
        for (int i = vsps_pkg::BUS_BITS - 1; i >= 0; i--)
        begin
            if (pgm_edges[i])
                pgm_idx = 3'(i);
            if (pvw_edges[i])
                pvw_idx = 3'(i);
        end
    end

    // Toggle: a new source is taken, the same source again clears it
    always_comb
    begin
        pgm_sel = state.program_selection;
        pvw_sel = state.preview_selection;
        if (pgm_hit)
            pgm_sel = (state.program_selection != {1'b0, pgm_idx}) ?
                      {1'b0, pgm_idx} : vsps_pkg::NONE_SEL;
        if (pvw_hit)
            pvw_sel = (state.preview_selection != {1'b0, pvw_idx}) ?
                      {1'b0, pvw_idx} : vsps_pkg::NONE_SEL;
    end

    // Swap buses when exactly one of cut and transition fired
    assign pgm_final = (cut_hit ^ trans_hit) ? pvw_sel : pgm_sel;
    assign pvw_final = (cut_hit ^ trans_hit) ? pgm_sel : pvw_sel;

    assign state_next.previous_pressed  = pressed;
    assign state_next.program_selection = pgm_final;
    assign state_next.preview_selection = pvw_final;

    // Build the result, LEDs only when something changed
    always_comb
    begin
        result.program_event    = pgm_hit;
        result.program_source   = pgm_sel;
        result.preview_event    = pvw_hit;
        result.preview_source   = pvw_sel;
        result.cut_event        = cut_hit;
        result.transition_event = trans_hit;
        result.leds_event       = any_hit;
        result.program_leds     = '0;
        result.preview_leds     = '0;
        if (any_hit && pgm_final < 4'(PGM_COUNT))
            result.program_leds = 8'b1 << pgm_final[2:0];
        if (any_hit && pvw_final < 4'(PVW_COUNT))
            result.preview_leds = 8'b1 << pvw_final[2:0];
    end

endmodule

>>> hdl/video_switcher_panel_selector_unit.sv
// ----------------------------------------------------------------------------
// video_switcher_panel_selector_unit: switcher panel program/preview selector
// Takes active-low button samples and returns selection events and LED masks.
// ----------------------------------------------------------------------------
//  channel | dir | width | content
//  s_axis  | in  | 24    | tdata[17:0] button_levels
//  m_axis  | out | 32    | tdata[28:0] result fields, see port comment
//
//  One beat in, one beat out; a new beat is taken every cycle while the
//  skid register is empty. The selection logic sits between the input
//  handshake and the output register.
//  A two-entry output stage (output register plus skid) keeps s_tready
//  registered, so a stalled master holds at most one extra beat.
//  Reset clears the previous button levels and both selections to none.
// ----------------------------------------------------------------------------
module video_switcher_panel_selector_unit #(
    parameter int PROGRAM_SOURCES = 8,
    parameter int PREVIEW_SOURCES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: button_levels[17:0], zero fill [23:18]
    input  logic [23:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: program_event[0], program_source[4:1], preview_event[5],
    // preview_source[9:6], cut_event[10], transition_event[11],
    // leds_event[12], program_leds[20:13], preview_leds[28:21], zero [31:29]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int PGM_COUNT = (PROGRAM_SOURCES > 8) ? 8 : PROGRAM_SOURCES;
    localparam int PVW_COUNT = (PREVIEW_SOURCES > 8) ? 8 : PREVIEW_SOURCES;

    vsps_pkg::sel_state_t state_reg;
    vsps_pkg::sel_state_t state_next;
    vsps_pkg::result_t    result;
    vsps_pkg::result_t    out_reg;
    vsps_pkg::result_t    skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_beat;
    logic                 out_beat;

    assign in_beat  = s_tvalid & s_tready;
    assign out_beat = out_valid_reg & m_tready;
    assign s_tready = ~skid_valid_reg;

    // Selection logic for the incoming beat
    vsps_select #(
        .PGM_COUNT(PGM_COUNT),
        .PVW_COUNT(PVW_COUNT)
    ) u_select (
        .button_levels(s_tdata[vsps_pkg::BTN_WIDTH-1:0]),
        .state        (state_reg),
        .state_next   (state_next),
        .result       (result)
    );

    // Advance the selection state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.previous_pressed  <= '0;
            state_reg.program_selection <= vsps_pkg::NONE_SEL;
            state_reg.preview_selection <= vsps_pkg::NONE_SEL;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
        end
    end

    // Output register and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
                out_valid_reg <= skid_valid_reg | in_beat;
            if (skid_valid_reg && m_tready)
                skid_valid_reg <= 1'b0;
            else if (in_beat && out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_reg <= skid_valid_reg ? skid_reg : result;
        if (in_beat && out_valid_reg && !m_tready)
            skid_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0,
                       out_reg.preview_leds,
                       out_reg.program_leds,
                       out_reg.leds_event,
                       out_reg.transition_event,
                       out_reg.cut_event,
                       out_reg.preview_source,
                       out_reg.preview_event,
                       out_reg.program_source,
                       out_reg.program_event};

    // Skid holds a beat only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output register empty");

    // LED flag matches the four event flags
    a_leds_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.leds_event == (out_reg.program_event |
            out_reg.preview_event | out_reg.cut_event | out_reg.transition_event)))
        else $error("leds_event does not match event flags");

    // LED masks are one-hot or zero, and zero without an event
    a_leds_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($onehot0(out_reg.program_leds) &&
            $onehot0(out_reg.preview_leds) &&
            (out_reg.leds_event || (out_reg.program_leds == '0 &&
                                    out_reg.preview_leds == '0))))
        else $error("LED mask malformed");

    // Selections only ever hold a valid source or none
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.program_selection <= vsps_pkg::NONE_SEL &&
        state_reg.preview_selection <= vsps_pkg::NONE_SEL)
        else $error("selection out of range");

endmodule
